// ===== hdl/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and codes for the generational handle table: request and
// response payloads, action and status codes, controller command bundle.
// ----------------------------------------------------------------------------
package ght_pkg;

   // fixed widths of the payload fields
   localparam int INDEX_BITS     = 10;
   localparam int VER_FIELD_BITS = 16;
   localparam int COMP_BITS      = 5;
   localparam int ACTION_BITS    = 3;
   localparam int STATUS_BITS    = 2;

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_CREATE  = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DESTROY = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_SET     = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_CLEAR   = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_TEST    = 3'd4;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_STALE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [ACTION_BITS-1:0]    action;
      logic [INDEX_BITS-1:0]     handle_index;
      logic [VER_FIELD_BITS-1:0] handle_version;
      logic [COMP_BITS-1:0]      component_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic [INDEX_BITS-1:0]     new_index;
      logic [VER_FIELD_BITS-1:0] new_version;
      logic                      present;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // request transfer this cycle, start ram reads
      logic execute;  // read-modify-write and load the response register
   } ctl_cmd_type;

endpackage

// ===== hdl/ght_ctrl.sv =====
// ----------------------------------------------------------------------------
// ght_ctrl
// Two-state sequencer: takes a request, then runs its execute cycle, and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module ght_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ght_pkg::ctl_cmd_type cmd
);
   import ght_pkg::*;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_take;
   logic      accept;

   // response register is free by the execute edge, nothing taken in reset
   assign can_take  = !reset && (state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign accept    = can_take && req_valid;
   assign req_stall = !can_take;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.accept  = accept;
   assign cmd.execute = (state_ff == S_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (state_ff == S_EXEC) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/ght_datapath.sv =====
// ----------------------------------------------------------------------------
// ght_datapath
// Slot ram, free-stack ram, fill and free counters, request decode and the
// response register.
// ----------------------------------------------------------------------------
module ght_datapath #(
   parameter int SLOT_COUNT      = 1024,
   parameter int VERSION_BITS    = 16,
   parameter int COMPONENT_COUNT = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ght_pkg::ctl_cmd_type cmd,
   input  ght_pkg::req_type     req,
   output ght_pkg::rsp_type     rsp
);
   import ght_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int EXT_W = (IDX_W > INDEX_BITS) ? IDX_W : INDEX_BITS;

   typedef struct packed {
      logic                       live;
      logic [VERSION_BITS-1:0]    version;
      logic [COMPONENT_COUNT-1:0] mask;
   } slot_type;

   // free entries carry the version the slot got when it was destroyed
   typedef struct packed {
      logic [IDX_W-1:0]        index;
      logic [VERSION_BITS-1:0] version;
   } free_type;

   slot_type slot_mem [SLOT_COUNT];
   free_type free_mem [SLOT_COUNT];

   slot_type slot_rd_ff;
   free_type free_rd_ff;
   req_type  req_ff;
   rsp_type  rsp_ff, rsp_in;

   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] used_ff, used_in;

   logic             slot_we;
   logic [IDX_W-1:0] slot_wa;
   slot_type         slot_wd;
   logic             free_we;
   logic [IDX_W-1:0] free_wa;
   free_type         free_wd;

   logic [EXT_W-1:0] req_idx_ext;
   logic [IDX_W-1:0] slot_ra;
   logic [IDX_W-1:0] free_ra;
   logic [CNT_W-1:0] free_top;

   logic [EXT_W-1:0]           idx_ext;
   logic [IDX_W-1:0]           addr;
   logic                       in_range;
   logic                       touched;
   logic                       ver_match;
   logic                       handle_ok;
   logic                       comp_ok;
   logic [COMPONENT_COUNT-1:0] comp_bit;
   logic                       bit_set;
   logic [VERSION_BITS-1:0]    ver_next;

   // read addresses straight from the request port and the stack top
   assign req_idx_ext = EXT_W'(req.handle_index);
   assign slot_ra     = req_idx_ext[IDX_W-1:0];
   assign free_top    = free_count_ff - 1'b1;
   assign free_ra     = free_top[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_rd_ff <= slot_mem[slot_ra];
         req_ff     <= req;
      end
      if (cmd.execute && slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         free_rd_ff <= free_mem[free_ra];
      end
      if (cmd.execute && free_we) begin
         free_mem[free_wa] <= free_wd;
      end
   end

   // slots at or above the fill count were never handed out: dead, version 0
   assign idx_ext   = EXT_W'(req_ff.handle_index);
   assign addr      = idx_ext[IDX_W-1:0];
   assign in_range  = 32'(idx_ext) < 32'(SLOT_COUNT);
   assign touched   = 32'(idx_ext) < 32'(used_ff);
   assign ver_match = 32'(slot_rd_ff.version) == 32'(req_ff.handle_version);
   assign handle_ok = in_range && touched && slot_rd_ff.live && ver_match;
   assign comp_ok   = 32'(req_ff.component_id) < 32'(COMPONENT_COUNT);
   assign comp_bit  = COMPONENT_COUNT'(1) << req_ff.component_id;
   assign bit_set   = |(slot_rd_ff.mask & comp_bit);
   assign ver_next  = slot_rd_ff.version + 1'b1;

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = ST_OK;
      free_count_in = free_count_ff;
      used_in       = used_ff;
      slot_we       = 1'b0;
      slot_wa       = addr;
      slot_wd       = slot_rd_ff;
      free_we       = 1'b0;
      free_wa       = free_count_ff[IDX_W-1:0];
      free_wd       = '{index: addr, version: ver_next};

      unique case (req_ff.action)
         ACT_CREATE: begin
            priority if (free_count_ff != '0) begin
               slot_we            = 1'b1;
               slot_wa            = free_rd_ff.index;
               slot_wd            = '{live: 1'b1, version: free_rd_ff.version, mask: '0};
               free_count_in      = free_count_ff - 1'b1;
               rsp_in.new_index   = INDEX_BITS'(free_rd_ff.index);
               rsp_in.new_version = VER_FIELD_BITS'(free_rd_ff.version);
            end else if (32'(used_ff) < 32'(SLOT_COUNT)) begin
               slot_we          = 1'b1;
               slot_wa          = IDX_W'(used_ff);
               slot_wd          = '{live: 1'b1, version: '0, mask: '0};
               used_in          = used_ff + 1'b1;
               rsp_in.new_index = INDEX_BITS'(used_ff);
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         ACT_DESTROY: begin
            if (handle_ok) begin
               slot_we = 1'b1;
               slot_wd = '{live: 1'b0, version: ver_next, mask: '0};
               if (32'(free_count_ff) < 32'(SLOT_COUNT)) begin
                  free_we       = 1'b1;
                  free_count_in = free_count_ff + 1'b1;
               end
            end else begin
               rsp_in.status = ST_STALE;
            end
         end
         ACT_SET, ACT_CLEAR, ACT_TEST: begin
            if (handle_ok && comp_ok) begin
               if (req_ff.action == ACT_SET) begin
                  slot_we      = 1'b1;
                  slot_wd.mask = slot_rd_ff.mask | comp_bit;
               end else if (req_ff.action == ACT_CLEAR) begin
                  slot_we      = 1'b1;
                  slot_wd.mask = slot_rd_ff.mask & ~comp_bit;
               end else begin
                  rsp_in.present = bit_set;
               end
            end else begin
               rsp_in.status = ST_STALE;
            end
         end
         default: begin
            rsp_in.status = ST_STALE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         used_ff       <= '0;
      end else if (cmd.execute) begin
         free_count_ff <= free_count_in;
         used_ff       <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== hdl/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table
// Table of versioned handles with a per-slot component bit mask: create,
// destroy, and set, clear or test of one component bit.
// ----------------------------------------------------------------------------
// For each request, the transfer cycle starts the registered reads of the slot
// ram (at the request's index) and of the free-stack ram (at the stack top);
// the next cycle does the read-modify-write of the slot entry,
// the stack push or pop and the counter updates, and loads the response
// register. A new request is taken in the cycle after that at the earliest, so
// the block takes no new request while one is still in flight.
// A response that waits under rsp_stall holds off the next request transfer
// until it is taken, and no request is taken while reset is high. There
// is no clearing pass after reset: slots at or above the fill count of
// never-used slots read as dead at version 0, and a free-stack entry carries
// the version the slot got at destroy, so a create from the stack needs no
// second slot read. Every request gives exactly one response.
// ----------------------------------------------------------------------------
module generational_handle_table #(
   parameter int SLOT_COUNT      = 1024,
   parameter int VERSION_BITS    = 16,
   parameter int COMPONENT_COUNT = 32
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  ght_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ght_pkg::rsp_type rsp_data
);
   import ght_pkg::*;

   ctl_cmd_type cmd;

   // sequencer: request transfer, execute cycle, response valid
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // slot and free-stack rams, counters, decode, response register
   ght_datapath #(
      .SLOT_COUNT      (SLOT_COUNT),
      .VERSION_BITS    (VERSION_BITS),
      .COMPONENT_COUNT (COMPONENT_COUNT)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .rsp   (rsp_data)
   );

   // every transfer is executed in the very next cycle
   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.execute)
      else $error("request transfer not followed by execute");

   // execute always presents a response
   a_exec_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("execute did not present a response");

   // one request in flight: no transfer right after a transfer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !cmd.accept)
      else $error("request taken during execute");

   // handle fields only on a successful create
   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |->
         ((rsp_data.new_index == '0) && (rsp_data.new_version == '0)))
      else $error("failed request returned a handle");

endmodule

// ===== bench/generational_handle_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_table_test
// Self-checking bench for the generational handle table. A queue of pending
// requests feeds a clocked driver. Each accepted request runs through a
// software copy of the table, and the predicted answer is queued. A clocked
// monitor checks every response against the oldest predicted answer. Stimulus
// is a short directed part, then random traffic that grows and thins the
// table, then a create/destroy loop on one slot that walks its version up.
// ----------------------------------------------------------------------------
module generational_handle_table_test;
   import ght_pkg::*;

   localparam int SLOT_COUNT      = 1024;
   localparam int VERSION_BITS    = 16;
   localparam int COMPONENT_COUNT = 32;
   localparam int BACKLOG_DEPTH   = 3;    // lookahead of the request generator
   localparam int REPORT_LIMIT    = 10;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WRAP_ROUNDS     = 40;

   typedef enum {MIX_CHURN, MIX_GROW, MIX_SHRINK} mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // requests not yet transferred, front one is on the bus
   req_type request_backlog[$];
   // answers predicted for transferred requests, oldest first
   rsp_type pending_answers[$];

   int failures  = 0;
   bit quiet     = 1'b0;   // no idling on either side
   int req_gap   = 0;
   int rsp_gap   = 0;

   // software copy of the table
   bit                        slot_live[SLOT_COUNT];
   logic [VER_FIELD_BITS-1:0] slot_ver[SLOT_COUNT];
   logic [31:0]               slot_bits[SLOT_COUNT];
   logic [INDEX_BITS-1:0]     free_stack[SLOT_COUNT];
   int                        free_top   = 0;
   int                        used_count = 0;

   generational_handle_table #(
      .SLOT_COUNT      (SLOT_COUNT),
      .VERSION_BITS    (VERSION_BITS),
      .COMPONENT_COUNT (COMPONENT_COUNT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // table prediction: applies one request, returns the answer it gives
   // ------------------------------------------------------------------------
   function automatic rsp_type apply_request(req_type r);
      rsp_type               a;
      int                    s;
      logic [INDEX_BITS-1:0] i;
      bit                    handle_good;
      a = '0;
      a.status = ST_OK;
      i = r.handle_index;
      // handle is good only on a live slot with the exact stored version
      handle_good = slot_live[i] && (slot_ver[i] == r.handle_version);
      case (r.action)
         ACT_CREATE: begin
            if (free_top > 0) begin
               // recycled slot keeps the version it got at destroy
               free_top--;
               s = free_stack[free_top];
            end else if (used_count < SLOT_COUNT) begin
               // fresh slot at version zero
               s = used_count;
               used_count++;
               slot_ver[s]  = '0;
               slot_bits[s] = '0;
            end else begin
               s = -1;
               a.status = ST_FULL;
            end
            if (s >= 0) begin
               slot_live[s]  = 1'b1;
               a.new_index   = INDEX_BITS'(s);
               a.new_version = slot_ver[s];
            end
         end
         ACT_DESTROY: begin
            if (handle_good) begin
               slot_ver[i]  = slot_ver[i] + 1'b1;   // wraps at the field width
               slot_bits[i] = '0;
               slot_live[i] = 1'b0;
               if (free_top < SLOT_COUNT) begin
                  free_stack[free_top] = i;
                  free_top++;
               end
            end else begin
               a.status = ST_STALE;
            end
         end
         ACT_SET, ACT_CLEAR, ACT_TEST: begin
            if (handle_good && r.component_id < COMPONENT_COUNT) begin
               if (r.action == ACT_SET)
                  slot_bits[i][r.component_id] = 1'b1;
               else if (r.action == ACT_CLEAR)
                  slot_bits[i][r.component_id] = 1'b0;
               else
                  a.present = slot_bits[i][r.component_id];
            end else begin
               a.status = ST_STALE;
            end
         end
         default: begin
            // unknown action codes
            a.status = ST_STALE;
         end
      endcase
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // request building
   // ------------------------------------------------------------------------
   function automatic req_type make_req(logic [ACTION_BITS-1:0]    act,
                                        logic [INDEX_BITS-1:0]     idx,
                                        logic [VER_FIELD_BITS-1:0] ver,
                                        logic [COMP_BITS-1:0]      comp);
      req_type r;
      r.action         = act;
      r.handle_index   = idx;
      r.handle_version = ver;
      r.component_id   = comp;
      return r;
   endfunction

   // random live slot among those ever used, 0 when none is live
   function automatic bit pick_live(output logic [INDEX_BITS-1:0] idx);
      int start;
      int k;
      idx = '0;
      if (used_count == 0)
         return 1'b0;
      start = $urandom_range(0, used_count - 1);
      for (k = 0; k < used_count; k++) begin
         idx = INDEX_BITS'((start + k) % used_count);
         if (slot_live[idx])
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic req_type random_request(mix_type mix);
      req_type               r;
      int                    roll;
      int                    cut[5];
      logic [INDEX_BITS-1:0] idx;
      // cumulative weights: create, destroy, set, clear, test; rest unknown
      case (mix)
         MIX_GROW:   cut = '{80, 86, 92, 95, 99};
         MIX_SHRINK: cut = '{10, 60, 75, 85, 97};
         default:    cut = '{24, 44, 64, 78, 96};
      endcase
      // ignored fields stay random too
      r.handle_index   = INDEX_BITS'($urandom);
      r.handle_version = VER_FIELD_BITS'($urandom);
      r.component_id   = COMP_BITS'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < cut[0])
         r.action = ACT_CREATE;
      else if (roll < cut[1])
         r.action = ACT_DESTROY;
      else if (roll < cut[2])
         r.action = ACT_SET;
      else if (roll < cut[3])
         r.action = ACT_CLEAR;
      else if (roll < cut[4])
         r.action = ACT_TEST;
      else
         r.action = ACTION_BITS'($urandom_range(ACT_TEST + 1, (1 << ACTION_BITS) - 1));
      if (r.action == ACT_CREATE)
         return r;
      if ($urandom_range(0, 99) < 85 && pick_live(idx)) begin
         // mostly a good handle, now and then one version bit off
         r.handle_index   = idx;
         r.handle_version = slot_ver[idx];
         if ($urandom_range(0, 9) == 0)
            r.handle_version = r.handle_version ^
                               (VER_FIELD_BITS'(1) << $urandom_range(0, VER_FIELD_BITS - 1));
      end else if (used_count > 0 && $urandom_range(0, 1) == 0) begin
         // old handle from before a destroy, or a dead slot
         r.handle_index   = INDEX_BITS'($urandom_range(0, used_count - 1));
         r.handle_version = slot_ver[r.handle_index] - VER_FIELD_BITS'($urandom_range(0, 1));
      end
      return r;
   endfunction

   task automatic queue_req(input req_type r);
      while (request_backlog.size() >= BACKLOG_DEPTH)
         @(negedge clock);
      request_backlog = {request_backlog, r};
   endtask

   task automatic wait_drained();
      while (request_backlog.size() != 0 || pending_answers.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // transfer done: predict its answer and retire it
         if (req_valid && !req_stall) begin
            pending_answers = {pending_answers, apply_request(req_data)};
            void'(request_backlog.pop_front());
         end
         if (req_valid && req_stall) begin
            // stalled payload stays as it is
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            // start an idle burst
            req_gap = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= request_backlog[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response monitor and stall generator
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: response with none awaited:", $realtime,
                           " status %0d index %0d", rsp_data.status, rsp_data.new_index,
                           " version %0d present %0d", rsp_data.new_version,
                           rsp_data.present);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.status !== want.status || rsp_data.new_index !== want.new_index ||
                   rsp_data.new_version !== want.new_version ||
                   rsp_data.present !== want.present) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%0t: mismatch: expected", $realtime,
                              " status %0d index %0d", want.status, want.new_index,
                              " version %0d present %0d,", want.new_version, want.present,
                              " got status %0d index %0d", rsp_data.status,
                              rsp_data.new_index,
                              " version %0d present %0d", rsp_data.new_version,
                              rsp_data.present);
               end
            end
         end
         // stall bursts
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and verdict
   // ------------------------------------------------------------------------
   initial begin
      logic [INDEX_BITS-1:0]     wrap_slot;
      logic [VER_FIELD_BITS-1:0] wrap_ver;
      int                        n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table: every handle is stale
      queue_req(make_req(ACT_TEST, '0, '0, '0));
      queue_req(make_req(ACT_DESTROY, '1, '1, '1));
      // first two creates take fresh slots 0 and 1
      queue_req(make_req(ACT_CREATE, '1, '1, '1));
      queue_req(make_req(ACT_CREATE, '0, '0, '0));
      // component bits at both ends
      queue_req(make_req(ACT_SET, 0, 0, '1));
      queue_req(make_req(ACT_SET, 0, 0, '0));
      queue_req(make_req(ACT_TEST, 0, 0, '1));
      queue_req(make_req(ACT_TEST, 0, 0, 1));
      queue_req(make_req(ACT_CLEAR, 0, 0, '1));
      queue_req(make_req(ACT_TEST, 0, 0, '1));
      // wrong version on a live slot
      queue_req(make_req(ACT_SET, 0, 1, 5));
      // unknown action codes
      for (n = ACT_TEST + 1; n < (1 << ACTION_BITS); n++)
         queue_req(make_req(ACTION_BITS'(n), '1, '1, '1));
      // destroy, then the same handle again
      queue_req(make_req(ACT_DESTROY, 1, 0, 0));
      queue_req(make_req(ACT_DESTROY, 1, 0, 0));
      queue_req(make_req(ACT_TEST, 1, 0, 0));
      // create reuses slot 1 at version 1 with a clean mask
      queue_req(make_req(ACT_CREATE, 0, 0, 0));
      queue_req(make_req(ACT_TEST, 1, 1, 0));
      // destroy with a bit still set, old handle goes stale
      queue_req(make_req(ACT_DESTROY, 0, 0, 3));
      queue_req(make_req(ACT_TEST, 0, 0, 0));
      queue_req(make_req(ACT_CREATE, 0, 0, 0));
      queue_req(make_req(ACT_TEST, 0, 1, 0));

      // random traffic with idling on both sides
      for (n = 0; n < 200; n++)
         queue_req(random_request(MIX_CHURN));
      // grow the table
      for (n = 0; n < 120; n++)
         queue_req(random_request(MIX_GROW));
      // thin it out again, alternating blocks
      for (n = 0; n < 120; n++)
         queue_req(random_request(((n / 40) % 2 == 0) ? MIX_SHRINK : MIX_CHURN));

      // last part: no idling on either side
      quiet = 1'b1;
      queue_req(make_req(ACT_CREATE, 0, 0, 0));
      wait_drained();
      void'(pick_live(wrap_slot));
      wrap_ver = slot_ver[wrap_slot];
      // lifo stack hands the same slot back each round, version walks up
      for (n = 0; n < WRAP_ROUNDS; n++) begin
         queue_req(make_req(ACT_DESTROY, wrap_slot, wrap_ver, COMP_BITS'($urandom)));
         queue_req(make_req(ACT_CREATE, INDEX_BITS'($urandom), VER_FIELD_BITS'($urandom),
                            COMP_BITS'($urandom)));
         wrap_ver = wrap_ver + 1'b1;
      end
      queue_req(make_req(ACT_SET, wrap_slot, wrap_ver, '1));
      queue_req(make_req(ACT_TEST, wrap_slot, wrap_ver, '1));
      queue_req(make_req(ACT_TEST, wrap_slot, wrap_ver - 1'b1, '1));
      for (n = 0; n < 120; n++)
         queue_req(random_request(MIX_CHURN));

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ght_pkg.sv
hdl/ght_ctrl.sv
hdl/ght_datapath.sv
hdl/generational_handle_table.sv
bench/generational_handle_table_test.sv
